FILE: rtl/ccl_pkg.sv
`default_nettype none
package ccl_pkg;

  // Default sizes of the frame and of the provisional label tables.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_LABELS_DEF = 8192;

  // Fixed port widths.
  localparam int LABEL_OUT_W = 13;
  localparam int DIM_W       = 9;
  localparam int PIX_W       = 8;
  localparam int REG_IDX_W   = 1;

  // Dimension registers reset to 256 pixels and rows.
  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(256);

  // Input item commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_LD_IDLE,
    ST_LD_UP,
    ST_FA_REQ,
    ST_FA_CHK,
    ST_FB_REQ,
    ST_FB_CHK,
    ST_MERGE,
    ST_RS_INIT,
    ST_RS_NEXT,
    ST_RS_REQ,
    ST_RS_CHK,
    ST_RS_FRD,
    ST_RS_FWR,
    ST_RD_IDLE,
    ST_RD_LAB,
    ST_RD_FIN
  } ccl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_start;
    logic ld_place;
    logic find_step;
    logic find_a_done;
    logic merge;
    logic rs_init;
    logic rs_next;
    logic rs_root;
    logic rs_copy;
    logic fin_lab_sel;
    logic rd_phase;
    logic rd_out;
  } ccl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_merge;
    logic last_pixel;
    logic load_done;
    logic less;
    logic at_self;
    logic rs_more;
    logic out_free;
    logic rd_last;
  } ccl_status_t;

endpackage
`default_nettype wire

FILE: rtl/ccl_ctrl.sv
`default_nettype none
module ccl_ctrl import ccl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_command,
  input  wire logic        cfg_we,
  input  wire ccl_status_t status,
  output logic             in_ready,
  output ccl_cmd_t         cmd
);

  ccl_state_t state_r, state_nxt;
  logic       acc;

  assign acc = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LD_IDLE: begin
        if (acc && in_command == CMD_LOAD) state_nxt = ST_LD_UP;
      end
      ST_LD_UP: begin
        if (status.need_merge)      state_nxt = ST_FA_REQ;
        else if (status.last_pixel) state_nxt = ST_RS_INIT;
        else                        state_nxt = ST_LD_IDLE;
      end
      ST_FA_REQ: state_nxt = ST_FA_CHK;
      ST_FA_CHK: state_nxt = status.less ? ST_FA_REQ : ST_FB_REQ;
      ST_FB_REQ: state_nxt = ST_FB_CHK;
      ST_FB_CHK: state_nxt = status.less ? ST_FB_REQ : ST_MERGE;
      ST_MERGE:  state_nxt = status.load_done ? ST_RS_INIT : ST_LD_IDLE;
      ST_RS_INIT: state_nxt = ST_RS_NEXT;
      ST_RS_NEXT: state_nxt = status.rs_more ? ST_RS_REQ : ST_RD_IDLE;
      ST_RS_REQ:  state_nxt = ST_RS_CHK;
      ST_RS_CHK: begin
        if (status.less)         state_nxt = ST_RS_REQ;
        else if (status.at_self) state_nxt = ST_RS_NEXT;
        else                     state_nxt = ST_RS_FRD;
      end
      ST_RS_FRD: state_nxt = ST_RS_FWR;
      ST_RS_FWR: state_nxt = ST_RS_NEXT;
      ST_RD_IDLE: begin
        if (acc && in_command == CMD_READ) state_nxt = ST_RD_LAB;
      end
      ST_RD_LAB: state_nxt = ST_RD_FIN;
      ST_RD_FIN: begin
        if (status.out_free) state_nxt = status.rd_last ? ST_LD_IDLE : ST_RD_IDLE;
      end
      default: state_nxt = ST_LD_IDLE;
    endcase
    if (cfg_we) state_nxt = ST_LD_IDLE;
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_LD_IDLE: begin
        in_ready     = 1'b1;
        cmd.ld_start = acc && in_command == CMD_LOAD;
      end
      ST_LD_UP:   cmd.ld_place = 1'b1;
      ST_FA_CHK: begin
        cmd.find_step   = status.less;
        cmd.find_a_done = !status.less;
      end
      ST_FB_CHK:  cmd.find_step = status.less;
      ST_MERGE:   cmd.merge = 1'b1;
      ST_RS_INIT: cmd.rs_init = 1'b1;
      ST_RS_NEXT: cmd.rs_next = status.rs_more;
      ST_RS_CHK: begin
        cmd.find_step = status.less;
        cmd.rs_root   = !status.less && status.at_self;
      end
      ST_RS_FWR:  cmd.rs_copy = 1'b1;
      ST_RD_IDLE: begin
        in_ready     = 1'b1;
        cmd.rd_phase = 1'b1;
      end
      ST_RD_LAB: begin
        cmd.rd_phase    = 1'b1;
        cmd.fin_lab_sel = 1'b1;
      end
      ST_RD_FIN: begin
        cmd.rd_phase    = 1'b1;
        cmd.fin_lab_sel = 1'b1;
        cmd.rd_out      = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ccl_datapath.sv
`default_nettype none
module ccl_datapath import ccl_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_LABELS = MAX_LABELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [PIX_W-1:0]       in_pixel_value,
  input  wire logic                   cfg_we,
  input  wire logic [REG_IDX_W-1:0]   cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data,
  input  wire ccl_cmd_t               cmd,
  output ccl_status_t                 status,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LABEL_OUT_W-1:0]      out_label,
  output logic                        out_last_label,
  output logic                        out_overflow
);

  localparam int LW       = $clog2(MAX_LABELS);
  localparam int PIXELS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW       = $clog2(PIXELS);
  localparam int PW       = AW + 1;
  localparam int XW       = $clog2(MAX_WIDTH);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST    = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int H_RST    = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int TOTAL_RST = W_RST * H_RST;
  localparam logic [LW-1:0] TOP = LW'(MAX_LABELS - 1);

  logic [LW-1:0] store_mem [PIXELS];
  logic [LW-1:0] par_mem   [MAX_LABELS];
  logic [LW-1:0] fin_mem   [MAX_LABELS];

  logic [DIM_W-1:0] width_r, height_r;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [PW-1:0]    total_r;
  logic [PW-1:0]    pos_r, rpos_r;
  logic [XW-1:0]    col_r;
  logic             row_nz_r;
  logic [LW-1:0]    left_r, np_r, cur_r, b_r, ra_r, cnt_r;
  logic [LW:0]      l_r;
  logic             ovf_r, fg_r;
  logic             out_valid_r, out_last_r, out_ovf_r;
  logic [LABEL_OUT_W-1:0] out_label_r;

  logic [LW-1:0] ls_rdata, par_rdata, fin_rdata;
  logic [AW-1:0] ls_raddr;
  logic [LW-1:0] fin_raddr;
  logic [LW-1:0] left, up, lab, fin_val;
  logic          new_lab, ovf_set, frame_clr;
  logic          par_we, fin_we;
  logic [LW-1:0] par_waddr, par_wdata, fin_waddr, fin_wdata;

  // Effective dimensions: zero counts as one, anything above the maximum is clamped.
  always_comb begin
    if (width_r == '0)                w_eff = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                               w_eff = WW'(width_r);
    if (height_r == '0)                 h_eff = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                 h_eff = HW'(height_r);
  end

  // Neighbors and the label of the current pixel.
  always_comb begin
    left    = (col_r != '0) ? left_r : '0;
    up      = row_nz_r ? ls_rdata : '0;
    lab     = '0;
    new_lab = 1'b0;
    ovf_set = 1'b0;
    if (fg_r) begin
      if (left != '0) begin
        lab = left;
      end else if (up != '0) begin
        lab = up;
      end else if (np_r < TOP) begin
        new_lab = 1'b1;
        lab     = np_r + LW'(1);
      end else begin
        ovf_set = 1'b1;
        lab     = TOP;
      end
    end
  end

  assign frame_clr = cfg_we | (cmd.rd_out & status.rd_last);
  assign ls_raddr  = cmd.rd_phase ? rpos_r[AW-1:0]
                                  : AW'(pos_r - PW'(w_eff));
  assign fin_raddr = cmd.fin_lab_sel ? ls_rdata : cur_r;
  assign fin_val   = (ls_rdata == '0) ? '0 : fin_rdata;

  always_comb begin
    status            = '0;
    status.need_merge = fg_r && left != '0 && up != '0 && up != left;
    status.last_pixel = (pos_r + PW'(1)) == total_r;
    status.load_done  = pos_r == total_r;
    status.less       = par_rdata < cur_r;
    status.at_self    = {1'b0, cur_r} == l_r;
    status.rs_more    = l_r <= {1'b0, np_r};
    status.out_free   = !out_valid_r || out_ready;
    status.rd_last    = (rpos_r + PW'(1)) == total_r;
  end

  // Union-find and final-number write ports.
  always_comb begin
    par_we    = 1'b0;
    par_waddr = lab;
    par_wdata = lab;
    if (cmd.ld_place && new_lab) begin
      par_we = 1'b1;
    end else if (cmd.merge) begin
      if (ra_r < cur_r) begin
        par_we    = 1'b1;
        par_waddr = cur_r;
        par_wdata = ra_r;
      end else if (cur_r < ra_r) begin
        par_we    = 1'b1;
        par_waddr = ra_r;
        par_wdata = cur_r;
      end
    end
    fin_we    = cmd.rs_root | cmd.rs_copy;
    fin_waddr = l_r[LW-1:0];
    fin_wdata = cmd.rs_root ? cnt_r + LW'(1) : fin_rdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_place) store_mem[pos_r[AW-1:0]] <= lab;
    ls_rdata <= store_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_waddr] <= par_wdata;
    par_rdata <= par_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (fin_we) fin_mem[fin_waddr] <= fin_wdata;
    fin_rdata <= fin_mem[fin_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_RST;
      height_r    <= DIM_RST;
      total_r     <= PW'(TOTAL_RST);
      pos_r       <= '0;
      rpos_r      <= '0;
      col_r       <= '0;
      row_nz_r    <= 1'b0;
      np_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r <= PW'(w_eff) * PW'(h_eff);
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
        if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
      end
      if (cmd.ld_place) begin
        pos_r <= pos_r + PW'(1);
        if (WW'(col_r) + WW'(1) == w_eff) begin
          col_r    <= '0;
          row_nz_r <= 1'b1;
        end else begin
          col_r <= col_r + XW'(1);
        end
        if (new_lab) np_r  <= lab;
        if (ovf_set) ovf_r <= 1'b1;
      end
      if (cmd.rd_out) begin
        rpos_r <= rpos_r + PW'(1);
      end
      if (cmd.rd_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (frame_clr) begin
        pos_r    <= '0;
        rpos_r   <= '0;
        col_r    <= '0;
        row_nz_r <= 1'b0;
        np_r     <= '0;
        ovf_r    <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_start) fg_r <= |in_pixel_value;
    if (cmd.ld_place) begin
      left_r <= lab;
      cur_r  <= left;
      b_r    <= up;
    end
    if (cmd.find_step) cur_r <= par_rdata;
    if (cmd.find_a_done) begin
      ra_r  <= cur_r;
      cur_r <= b_r;
    end
    if (cmd.rs_init) begin
      l_r   <= (LW + 1)'(1);
      cnt_r <= '0;
    end
    if (cmd.rs_next) cur_r <= l_r[LW-1:0];
    if (cmd.rs_root) begin
      cnt_r <= cnt_r + LW'(1);
      l_r   <= l_r + (LW + 1)'(1);
    end
    if (cmd.rs_copy) l_r <= l_r + (LW + 1)'(1);
    if (cmd.rd_out) begin
      out_label_r <= LABEL_OUT_W'(fin_val);
      out_last_r  <= status.rd_last;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_label      = out_label_r;
  assign out_last_label = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule
`default_nettype wire

FILE: rtl/connected_component_labeler_4conn.sv
// Two-pass 4-connected component labeler for binary images.
// Input items carry a command and a pixel byte. In the loading phase a load
// command takes one pixel in raster order; a nonzero byte is foreground.
// A load is accepted in ST_LD_IDLE and placed in ST_LD_UP. A pixel that joins
// two differently labeled neighbors then walks both to their roots, one parent
// step at a time, and merges the two roots in ST_MERGE.
// After the last pixel the block resolves the table, walking every
// provisional label to its root, and takes no item meanwhile. Read commands
// then stream the final labels out, one result item per read, with
// last_label set on the frame's final pixel and overflow set if provisional
// labels ran out. A read passes through ST_RD_LAB and ST_RD_FIN, which writes
// its result to the output register. Reads during loading and loads during
// readout are consumed without a result.
// A stalled receiver holds the result in the output register; the next read
// can be accepted meanwhile and waits for the register to empty.
// Reset selects a 256 by 256 frame and the loading phase; no clearing pass
// is needed. Writing a dimension register restarts the frame.
`default_nettype none
module connected_component_labeler_4conn import ccl_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_LABELS = MAX_LABELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  input  wire logic [PIX_W-1:0]       in_pixel_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LABEL_OUT_W-1:0]      out_label,
  output logic                        out_last_label,
  output logic                        out_overflow,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [REG_IDX_W-1:0]   cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data
);

  ccl_cmd_t    cmd;
  ccl_status_t status;
  logic        cfg_we;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  ccl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .cfg_we     (cfg_we),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  ccl_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LABELS (MAX_LABELS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pixel_value (in_pixel_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_label      (out_label),
    .out_last_label (out_last_label),
    .out_overflow   (out_overflow)
  );

endmodule
`default_nettype wire

FILE: tb/connected_component_labeler_4conn_test.sv
`timescale 1ns / 1ps
module connected_component_labeler_4conn_test;
  import ccl_pkg::*;

  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int MAXH = MAX_HEIGHT_DEF;
  localparam int LTOP = MAX_LABELS_DEF - 1;
  localparam int STALL_LIMIT = 200000;

  // One input item as the driver presents it.
  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pix;
  } pixel_cmd_t;

  // One expected label result.
  typedef struct packed {
    logic [LABEL_OUT_W-1:0] label;
    logic                   last;
    logic                   ovf;
  } label_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_LOAD;
  logic [PIX_W-1:0] in_pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LABEL_OUT_W-1:0] out_label;
  logic out_last_label;
  logic out_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  connected_component_labeler_4conn i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_pixel_value(in_pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_label     (out_label),
    .out_last_label(out_last_label),
    .out_overflow  (out_overflow),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Items waiting for the driver, and labels waiting to be seen on the output.
  pixel_cmd_t pending_pixels[$];
  label_res_t expected_labels[$];
  int errors = 0;
  bit quiet = 1'b0;
  int sent_items = 0;

  // ---------------------------------------------------------------------------
  // Labeler predictor: its own copy of the label memory, the union-find table
  // and the final numbering, updated on every accepted item.
  // ---------------------------------------------------------------------------
  logic [LABEL_OUT_W-1:0] lab_mem[MAXW*MAXH];
  logic [LABEL_OUT_W-1:0] parent_tbl[LTOP+1];
  logic [LABEL_OUT_W-1:0] final_tbl[LTOP+1];
  logic [DIM_W-1:0] reg_w = DIM_RST;
  logic [DIM_W-1:0] reg_h = DIM_RST;
  int load_pos, read_pos, last_prov;
  bit reading, lab_ovf;

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int cap);
    if (v == 0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic int find_root(int x);
    while (int'(parent_tbl[x]) < x) x = int'(parent_tbl[x]);
    return x;
  endfunction

  function automatic void restart_frame();
    load_pos = 0;
    read_pos = 0;
    last_prov = 0;
    reading = 1'b0;
    lab_ovf = 1'b0;
  endfunction

  // Numbers the roots densely in order of their first provisional label.
  function automatic void number_components();
    int cnt;
    int r;
    cnt = 0;
    for (int l = 1; l <= last_prov; l++) begin
      r = find_root(l);
      if (r == l) begin
        cnt++;
        final_tbl[l] = LABEL_OUT_W'(cnt);
      end else begin
        final_tbl[l] = final_tbl[r];
      end
    end
  endfunction

  function automatic void predict_labels(pixel_cmd_t it);
    int w, h, total, left, up, lab, ra, rb;
    label_res_t res;
    w = clamp_dim(reg_w, MAXW);
    h = clamp_dim(reg_h, MAXH);
    total = w * h;
    if (it.cmd == CMD_LOAD) begin
      if (reading || load_pos >= total) return;
      left = 0;
      up = 0;
      lab = 0;
      if (load_pos % w != 0) left = int'(lab_mem[load_pos-1]);
      if (load_pos >= w) up = int'(lab_mem[load_pos-w]);
      if (it.pix != 0) begin
        if (left != 0) begin
          lab = left;
          if (up != 0 && up != left) begin
            ra = find_root(left);
            rb = find_root(up);
            if (ra < rb) parent_tbl[rb] = LABEL_OUT_W'(ra);
            else if (rb < ra) parent_tbl[ra] = LABEL_OUT_W'(rb);
          end
        end else if (up != 0) begin
          lab = up;
        end else if (last_prov < LTOP) begin
          last_prov++;
          parent_tbl[last_prov] = LABEL_OUT_W'(last_prov);
          lab = last_prov;
        end else begin
          // Table exhausted: the new component shares the top label.
          lab_ovf = 1'b1;
          lab = LTOP;
        end
      end
      lab_mem[load_pos] = LABEL_OUT_W'(lab);
      load_pos++;
      if (load_pos >= total) begin
        number_components();
        reading = 1'b1;
      end
    end else begin
      if (!reading || read_pos >= total) return;
      lab = int'(lab_mem[read_pos]);
      res.label = (lab != 0) ? final_tbl[lab] : '0;
      res.last = (read_pos + 1 == total);
      res.ovf = lab_ovf;
      expected_labels.insert(expected_labels.size(), res);
      read_pos++;
      if (res.last) restart_frame();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, with random gaps unless quiet is set.
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  always @(posedge clk) begin
    pixel_cmd_t nxt;
    if (rst_n && (!in_valid || in_ready)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        nxt = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.cmd;
        in_pixel_value <= nxt.pix;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls in bursts as well.
  int out_gap = 0;
  always @(posedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_gap <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: feeds the predictor with every accepted item and register write,
  // and checks each result against the oldest expectation.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    label_res_t exp_res;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) reg_w = cfg_data;
        else reg_h = cfg_data;
        restart_frame();
      end
      if (in_valid && in_ready) predict_labels('{in_command, in_pixel_value});
      if (out_valid && out_ready) begin
        if (expected_labels.size() == 0) begin
          if (errors < 10) $display("unexpected label %0d last %0b ovf %0b",
                                    out_label, out_last_label, out_overflow);
          errors++;
        end else begin
          exp_res = expected_labels.pop_front();
          if (exp_res.label !== out_label || exp_res.last !== out_last_label ||
              exp_res.ovf !== out_overflow) begin
            if (errors < 10)
              $display("label mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       exp_res.label, exp_res.last, exp_res.ovf,
                       out_label, out_last_label, out_overflow);
            errors++;
          end
        end
      end
      // Watchdog: the run has hung if nothing moves for too long.
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  int frame_w = MAXW;
  int frame_h = MAXH;

  function automatic logic [PIX_W-1:0] rand_pixel(int density);
    if ($urandom_range(0, 99) < density) return PIX_W'($urandom_range(1, 255));
    return '0;
  endfunction

  // Appends one item to the driver's queue and counts it.
  task automatic add_item(pixel_cmd_t it);
    pending_pixels.insert(pending_pixels.size(), it);
    sent_items++;
  endtask

  // Blocks until the sender and the receiver have nothing outstanding, then
  // lets the block finish any resolve pass that produces no result.
  task automatic wait_drained();
    while (pending_pixels.size() > 0 || in_valid || expected_labels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    frame_w = clamp_dim(w, MAXW);
    frame_h = clamp_dim(h, MAXH);
  endtask

  // Queues a whole frame of loads followed by its reads. With noise, stray
  // reads land in the loading phase and stray loads in the readout, where the
  // block must drop them.
  task automatic queue_frame(int density, bit noise);
    int n;
    n = frame_w * frame_h;
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0) add_item('{CMD_READ, 8'hFF});
      add_item('{CMD_LOAD, rand_pixel(density)});
    end
    for (int i = 0; i < n; i++) begin
      if (noise && i > 0 && $urandom_range(0, 9) == 0)
        add_item('{CMD_LOAD, 8'hFF});
      add_item('{CMD_READ, 8'h00});
    end
  endtask

  task automatic queue_loads(logic [PIX_W-1:0] p[]);
    foreach (p[i]) add_item('{CMD_LOAD, p[i]});
  endtask

  task automatic queue_reads(int n);
    for (int i = 0; i < n; i++) add_item('{CMD_READ, 8'h00});
  endtask

  initial begin
    restart_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A zero width and height count as a single pixel. A read while loading
    // and a load during readout are both dropped.
    set_dims('0, '0);
    add_item('{CMD_READ, 8'h00});
    queue_loads('{8'h80});
    add_item('{CMD_LOAD, 8'h01});
    queue_reads(1);

    // A U shape: the right arm merges into the left one on the bottom row.
    set_dims(9'd4, 9'd3);
    queue_loads('{8'hFF, 8'h00, 8'h01, 8'h00,
                  8'h7F, 8'h00, 8'h02, 8'h00,
                  8'h55, 8'hAA, 8'h04, 8'h00});
    queue_reads(12);

    // A register write in mid-frame throws the partial frame away.
    set_dims(9'd3, 9'd2);
    queue_loads('{8'hFF, 8'h00, 8'h10});
    set_dims(9'd2, 9'd2);
    queue_loads('{8'h00, 8'h20, 8'h40, 8'h08});
    queue_reads(4);

    // A width above the maximum clamps to it: one full-width row.
    set_dims(9'h1FF, 9'd1);
    queue_frame(50, 1'b0);

    // Random frames of small sizes, some of them long and flat.
    while (sent_items < 750) begin
      if ($urandom_range(0, 3) == 0)
        set_dims(DIM_W'($urandom_range(1, 24)), DIM_W'($urandom_range(1, 3)));
      else if (frame_w * frame_h > 64 || $urandom_range(0, 1) == 0)
        set_dims(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
      else
        wait_drained();
      if (sent_items > 650) quiet = 1'b1;
      queue_frame($urandom_range(10, 90), $urandom_range(0, 2) == 0);
    end

    wait_drained();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ccl_pkg.sv
rtl/ccl_ctrl.sv
rtl/ccl_datapath.sv
rtl/connected_component_labeler_4conn.sv
tb/connected_component_labeler_4conn_test.sv
